// ----- hw/rtl/aes_pkg.sv -----
// Shared types, codes and S-box tables of the AES-128 block core.
// No dependencies; the top level, the key schedule and the round cell refer to this package.
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;

  localparam logic [HalfW-1:0] KeyFirstReset  = 64'hf530357968578480;
  localparam logic [HalfW-1:0] KeySecondReset = 64'hb398a3c251cd1093;

  // Configuration register indexes.
  localparam logic CfgKeyFirst  = 1'b0;
  localparam logic CfgKeySecond = 1'b1;

  // Operation codes.
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [7:0] sbox_tbl_t [256];

  // Control that travels with a block from one round cell to the next.
  typedef struct packed {
    logic valid;
    logic op;
  } stage_ctl_t;

  typedef logic [BlockW-1:0] round_keys_t [NumRounds+1];

  localparam sbox_tbl_t FwdSbox = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
    8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
    8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
    8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
    8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
    8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
    8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
    8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
    8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
    8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
    8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
    8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // The inverse table is derived from the forward one at elaboration.
  function automatic sbox_tbl_t gen_inv_sbox();
    sbox_tbl_t t;
    for (int k = 0; k < 256; k++) begin
      t[FwdSbox[k]] = k[7:0];
    end
    return t;
  endfunction

  localparam sbox_tbl_t InvSbox = gen_inv_sbox();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block sits at bits 127-8k down to 120-8k.
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int k);
    return s[BlockW-1-8*k -: 8];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes_in_if.sv -----
// Input channel of the AES-128 core: one block and its operation per beat.
// Depends on nothing but the language.
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_first_half;
  logic [63:0] block_second_half;

  modport source (output valid, op, block_first_half, block_second_half, input ready);
  modport sink   (input valid, op, block_first_half, block_second_half, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aes_out_if.sv -----
// Output channel of the AES-128 core: one result block per beat.
// Depends on nothing but the language.
`default_nettype none
interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_first_half;
  logic [63:0] result_second_half;

  modport source (output valid, result_first_half, result_second_half, input ready);
  modport sink   (input valid, result_first_half, result_second_half, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aes128_block_encrypt_decrypt_core.sv -----
// Top level of the AES-128 encrypt/decrypt core: entry stage, ten round cells, key schedule.
// Depends on aes_pkg, aes_in_if, aes_out_if, aes_key_sched and aes_round_cell.
`default_nettype none
// AES-128 block core. Each input beat carries one 128-bit block and an
// operation bit (0 encrypts, 1 decrypts); each output beat carries the
// matching result, in the order the blocks came in. The core accepts one
// block per cycle while input ready is high: an entry stage applies the
// first round key, then a chain of ten round cells does one round each and
// hands the block to its neighbor. The last cell is the output register, so
// a stalled output freezes the whole chain and input ready drops with it.
// The round keys are held in registers filled by a key schedule that derives
// one round key per cycle. After reset and after every key register write it
// derives every round key anew, a write restarting it, and input ready stays
// low meanwhile; configuration writes are taken at any time.
module aes128_block_encrypt_decrypt_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [aes_pkg::HalfW-1:0] cfg_data_i,
  aes_in_if.sink                         in_ch_i,
  aes_out_if.source                      out_ch_o
);

  aes_pkg::round_keys_t       rk;
  logic                       ks_busy;
  logic                       advance;
  aes_pkg::stage_ctl_t        ctl [aes_pkg::NumRounds+1];
  logic [aes_pkg::BlockW-1:0] st  [aes_pkg::NumRounds+1];
  logic [aes_pkg::BlockW-1:0] blk, blk_keyed;
  aes_pkg::stage_ctl_t        entry_ctl_q;
  logic [aes_pkg::BlockW-1:0] entry_state_q;

  aes_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rk_o       (rk),
    .busy_o     (ks_busy)
  );

  // The chain moves as a whole whenever the output register is free or drained.
  assign advance        = !ctl[aes_pkg::NumRounds].valid || out_ch_o.ready;
  assign in_ch_i.ready  = advance && !ks_busy;

  // Encryption starts with round key 0, decryption with the last round key.
  assign blk       = {in_ch_i.block_first_half, in_ch_i.block_second_half};
  assign blk_keyed = blk ^ ((in_ch_i.op == aes_pkg::OpDecrypt) ? rk[aes_pkg::NumRounds] : rk[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_ctl_q <= '0;
    end else if (advance) begin
      entry_ctl_q.valid <= in_ch_i.valid && !ks_busy;
      entry_ctl_q.op    <= in_ch_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      entry_state_q <= blk_keyed;
    end
  end

  assign ctl[0] = entry_ctl_q;
  assign st[0]  = entry_state_q;

  // Cell i runs forward round i or inverse round 10-i; the last one skips the mixing.
  for (genvar i = 1; i <= aes_pkg::NumRounds; i++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .mix_en_i  (i != aes_pkg::NumRounds),
      .rk_enc_i  (rk[i]),
      .rk_dec_i  (rk[aes_pkg::NumRounds-i]),
      .ctl_i     (ctl[i-1]),
      .state_i   (st[i-1]),
      .ctl_o     (ctl[i]),
      .state_o   (st[i])
    );
  end

  assign out_ch_o.valid              = ctl[aes_pkg::NumRounds].valid;
  assign out_ch_o.result_first_half  = st[aes_pkg::NumRounds][aes_pkg::BlockW-1:aes_pkg::HalfW];
  assign out_ch_o.result_second_half = st[aes_pkg::NumRounds][aes_pkg::HalfW-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/aes_key_sched.sv -----
// Key registers and round key expansion, one round key per cycle unless a key write restarts it.
// Depends on aes_pkg.
`default_nettype none
module aes_key_sched (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [aes_pkg::HalfW-1:0]  cfg_data_i,
  output aes_pkg::round_keys_t            rk_o,
  output logic                            busy_o
);

  logic [aes_pkg::HalfW-1:0]  key_first_q, key_second_q;
  logic [aes_pkg::BlockW-1:0] cur_q, cur_d, next_key;
  logic [aes_pkg::BlockW-1:0] rk_q [1:aes_pkg::NumRounds];
  logic [7:0]                 rc_q;
  logic [3:0]                 cnt_q;
  logic                       busy_q;

  always_comb begin
    logic [31:0] t;
    logic [31:0] w;
    t = {aes_pkg::FwdSbox[aes_pkg::get_byte(cur_q, 13)] ^ rc_q,
         aes_pkg::FwdSbox[aes_pkg::get_byte(cur_q, 14)],
         aes_pkg::FwdSbox[aes_pkg::get_byte(cur_q, 15)],
         aes_pkg::FwdSbox[aes_pkg::get_byte(cur_q, 12)]};
    w = t;
    for (int j = 0; j < 4; j++) begin
      w = w ^ cur_q[aes_pkg::BlockW-1-32*j -: 32];
      next_key[aes_pkg::BlockW-1-32*j -: 32] = w;
    end
  end

  always_comb begin
    cur_d = next_key;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_pkg::CfgKeyFirst:  cur_d = {cfg_data_i, key_second_q};
        aes_pkg::CfgKeySecond: cur_d = {key_first_q, cfg_data_i};
        default:               cur_d = next_key;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= aes_pkg::KeyFirstReset;
      key_second_q <= aes_pkg::KeySecondReset;
      cur_q        <= {aes_pkg::KeyFirstReset, aes_pkg::KeySecondReset};
      rc_q         <= 8'h01;
      cnt_q        <= 4'd1;
      busy_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_pkg::CfgKeyFirst:  key_first_q  <= cfg_data_i;
        aes_pkg::CfgKeySecond: key_second_q <= cfg_data_i;
        default: ;
      endcase
      cur_q  <= cur_d;
      rc_q   <= 8'h01;
      cnt_q  <= 4'd1;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cur_q <= cur_d;
      rc_q  <= aes_pkg::xtime(rc_q);
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'(aes_pkg::NumRounds)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we_i) begin
      rk_q[cnt_q] <= next_key;
    end
  end

  always_comb begin
    rk_o[0] = {key_first_q, key_second_q};
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      rk_o[r] = rk_q[r];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

// ----- hw/rtl/aes_round_cell.sv -----
// One round cell of the cipher chain, forward or inverse round per block.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic                       mix_en_i,
  input  wire logic [aes_pkg::BlockW-1:0] rk_enc_i,
  input  wire logic [aes_pkg::BlockW-1:0] rk_dec_i,
  input  wire aes_pkg::stage_ctl_t        ctl_i,
  input  wire logic [aes_pkg::BlockW-1:0] state_i,
  output aes_pkg::stage_ctl_t             ctl_o,
  output logic [aes_pkg::BlockW-1:0]      state_o
);

  aes_pkg::stage_ctl_t        ctl_q;
  logic [aes_pkg::BlockW-1:0] state_q, state_d, enc_v, dec_v;

  // Forward round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  always_comb begin
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[4*c+k] = aes_pkg::FwdSbox[aes_pkg::get_byte(state_i, 4*((c+k)%4)+k)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      if (mix_en_i) begin
        t[4*c]   = aes_pkg::xtime(a0 ^ a1) ^ a0 ^ x;
        t[4*c+1] = aes_pkg::xtime(a1 ^ a2) ^ a1 ^ x;
        t[4*c+2] = aes_pkg::xtime(a2 ^ a3) ^ a2 ^ x;
        t[4*c+3] = aes_pkg::xtime(a3 ^ a0) ^ a3 ^ x;
      end
    end
    for (int k = 0; k < 16; k++) begin
      enc_v[aes_pkg::BlockW-1-8*k -: 8] = t[k] ^ aes_pkg::get_byte(rk_enc_i, k);
    end
  end

  // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns.
  always_comb begin
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] c9 [4];
    logic [7:0] cb [4];
    logic [7:0] cd [4];
    logic [7:0] ce [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[4*((c+k)%4)+k] = aes_pkg::InvSbox[aes_pkg::get_byte(state_i, 4*c+k)];
      end
    end
    for (int k = 0; k < 16; k++) begin
      t[k] = t[k] ^ aes_pkg::get_byte(rk_dec_i, k);
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = t[4*c+k];
        m2[k] = aes_pkg::xtime(a[k]);
        m4[k] = aes_pkg::xtime(m2[k]);
        m8[k] = aes_pkg::xtime(m4[k]);
        c9[k] = m8[k] ^ a[k];
        cb[k] = m8[k] ^ m2[k] ^ a[k];
        cd[k] = m8[k] ^ m4[k] ^ a[k];
        ce[k] = m8[k] ^ m4[k] ^ m2[k];
      end
      if (mix_en_i) begin
        t[4*c]   = ce[0] ^ cb[1] ^ cd[2] ^ c9[3];
        t[4*c+1] = c9[0] ^ ce[1] ^ cb[2] ^ cd[3];
        t[4*c+2] = cd[0] ^ c9[1] ^ ce[2] ^ cb[3];
        t[4*c+3] = cb[0] ^ cd[1] ^ c9[2] ^ ce[3];
      end
    end
    for (int k = 0; k < 16; k++) begin
      dec_v[aes_pkg::BlockW-1-8*k -: 8] = t[k];
    end
  end

  assign state_d = (ctl_i.op == aes_pkg::OpDecrypt) ? dec_v : enc_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (advance_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign state_o = state_q;

endmodule
`default_nettype wire
